// ----- sv/sgi_pkg.sv -----
// Package for the 2D segment intersection pipeline: widths, types, divider step.
package sgi_pkg;

	localparam int CW    = 16;             // coordinate width
	localparam int AW    = CW + 1;         // line coefficients a, b
	localparam int PW    = 2 * CW;         // coordinate products
	localparam int CCW   = PW + 1;         // line constant c
	localparam int RPW   = AW + CW;        // side-value terms
	localparam int RW    = RPW + 2;        // side values r1..r4
	localparam int DPW   = 2 * AW;         // denominator terms
	localparam int DENW  = DPW + 1;        // denominator
	localparam int NPW   = AW + CCW;       // numerator terms
	localparam int NUMW  = NPW + 1;        // numerators
	localparam int HW    = (RW + 1) / 2;   // half width for side-product partials
	localparam int PRW   = 4 * HW;         // side-product width
	localparam int PTW   = 48;             // product threshold width
	localparam int CTW   = 32;             // collinear threshold width
	localparam int QB    = CW + 1;         // quotient bits
	localparam int DMW   = DENW;           // denominator magnitude
	localparam int NMW   = NUMW;           // numerator magnitude
	localparam int IDXW  = 1;

	localparam logic [IDXW-1:0] REG_PRODUCT_THR   = 1'd0;
	localparam logic [IDXW-1:0] REG_COLLINEAR_THR = 1'd1;

	typedef struct packed {
		logic           vld;
		logic           hit;
		logic           negx;
		logic           negy;
		logic [NMW-1:0] nx;
		logic [NMW-1:0] ny;
		logic [DMW-1:0] dm;
	} div_in_t;

	typedef struct packed {
		logic          vld;
		logic          hit;
		logic [CW-1:0] ix;
		logic [CW-1:0] iy;
	} div_out_t;

	typedef struct packed {
		logic [DMW-1:0] rem;
		logic           q;
	} div_step_t;

	// one restoring division step
	function automatic div_step_t div_step(logic [DMW-1:0] rem, logic nbit, logic [DMW-1:0] d);
		logic [DMW:0] t;
		logic [DMW:0] diff;
		div_step_t    res;
		t    = {rem, nbit};
		diff = t - {1'b0, d};
		res.q   = (t >= {1'b0, d});
		res.rem = res.q ? diff[DMW-1:0] : t[DMW-1:0];
		return res;
	endfunction

endpackage

// ----- sv/sgi_in_if.sv -----
// Input channel: two segments per transfer.
interface sgi_in_if;
	logic                            valid;
	logic                            ready;
	logic signed [sgi_pkg::CW-1:0]   ax;
	logic signed [sgi_pkg::CW-1:0]   ay;
	logic signed [sgi_pkg::CW-1:0]   bx;
	logic signed [sgi_pkg::CW-1:0]   by_coord;
	logic signed [sgi_pkg::CW-1:0]   cx;
	logic signed [sgi_pkg::CW-1:0]   cy;
	logic signed [sgi_pkg::CW-1:0]   dx;
	logic signed [sgi_pkg::CW-1:0]   dy;

	modport source (output valid, ax, ay, bx, by_coord, cx, cy, dx, dy, input ready);
	modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, dx, dy, output ready);
endinterface

// ----- sv/sgi_out_if.sv -----
// Output channel: hit flag and crossing point per transfer.
interface sgi_out_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic signed [sgi_pkg::CW-1:0] ix;
	logic signed [sgi_pkg::CW-1:0] iy;

	modport source (output valid, hit, ix, iy, input ready);
	modport sink   (input valid, hit, ix, iy, output ready);
endinterface

// ----- sv/sgi_div.sv -----
// Pipelined restoring divider, two lanes (x and y), one quotient bit per stage.
module sgi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  sgi_pkg::div_in_t   din,
	output sgi_pkg::div_out_t  dout
);
	localparam int QB  = sgi_pkg::QB;
	localparam int DMW = sgi_pkg::DMW;
	localparam int NMW = sgi_pkg::NMW;
	localparam int CW  = sgi_pkg::CW;

	logic           vld_s  [QB+1];
	logic           hit_s  [QB+1];
	logic           negx_s [QB+1];
	logic           negy_s [QB+1];
	logic [DMW-1:0] dm_s   [QB+1];
	logic [DMW-1:0] rx_s   [QB+1];
	logic [DMW-1:0] ry_s   [QB+1];
	logic [QB-1:0]  lx_s   [QB+1];
	logic [QB-1:0]  ly_s   [QB+1];
	logic [QB-1:0]  qx_s   [QB+1];
	logic [QB-1:0]  qy_s   [QB+1];

	logic           vld_q;
	logic           hit_q;
	logic [CW-1:0]  ix_q;
	logic [CW-1:0]  iy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s[0]  <= din.hit;
			negx_s[0] <= din.negx;
			negy_s[0] <= din.negy;
			dm_s[0]   <= din.dm;
			rx_s[0]   <= DMW'(din.nx[NMW-1:QB]);
			ry_s[0]   <= DMW'(din.ny[NMW-1:QB]);
			lx_s[0]   <= din.nx[QB-1:0];
			ly_s[0]   <= din.ny[QB-1:0];
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_step
		sgi_pkg::div_step_t sx;
		sgi_pkg::div_step_t sy;

		always_comb begin
			sx = sgi_pkg::div_step(rx_s[k-1], lx_s[k-1][QB-1], dm_s[k-1]);
			sy = sgi_pkg::div_step(ry_s[k-1], ly_s[k-1][QB-1], dm_s[k-1]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hit_s[k]  <= hit_s[k-1];
				negx_s[k] <= negx_s[k-1];
				negy_s[k] <= negy_s[k-1];
				dm_s[k]   <= dm_s[k-1];
				rx_s[k]   <= sx.rem;
				ry_s[k]   <= sy.rem;
				lx_s[k]   <= {lx_s[k-1][QB-2:0], 1'b0};
				ly_s[k]   <= {ly_s[k-1][QB-2:0], 1'b0};
				qx_s[k]   <= {qx_s[k-1][QB-2:0], sx.q};
				qy_s[k]   <= {qy_s[k-1][QB-2:0], sy.q};
			end
		end
	end

	logic [QB-1:0] qx_f;
	logic [QB-1:0] qy_f;

	always_comb begin
		qx_f = negx_s[QB] ? (~qx_s[QB] + QB'(1)) : qx_s[QB];
		qy_f = negy_s[QB] ? (~qy_s[QB] + QB'(1)) : qy_s[QB];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hit_s[QB];
			ix_q  <= hit_s[QB] ? qx_f[CW-1:0] : '0;
			iy_q  <= hit_s[QB] ? qy_f[CW-1:0] : '0;
		end
	end

	assign dout.vld = vld_q;
	assign dout.hit = hit_q;
	assign dout.ix  = ix_q;
	assign dout.iy  = iy_q;

endmodule

// ----- sv/segment_intersection_2d.sv -----
// Top level: 2D segment intersection, side tests, thresholds and crossing point.
// Accepts one item per cycle while the output is not stalled; the datapath is fully pipelined:
// 7 arithmetic stages, then an 18-stage bit-per-stage divider and an output register.
// Stalls freeze all stages.
// Reset clears valid bits and sets both thresholds to 1.
module segment_intersection_2d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sgi_pkg::IDXW-1:0]      cfg_idx,
	input  logic [sgi_pkg::PTW-1:0]       cfg_wdata,
	sgi_in_if.sink                        seg_in,
	sgi_out_if.source                     seg_out
);
	localparam int CW   = sgi_pkg::CW;
	localparam int AW   = sgi_pkg::AW;
	localparam int PW   = sgi_pkg::PW;
	localparam int CCW  = sgi_pkg::CCW;
	localparam int RPW  = sgi_pkg::RPW;
	localparam int RW   = sgi_pkg::RW;
	localparam int DPW  = sgi_pkg::DPW;
	localparam int DENW = sgi_pkg::DENW;
	localparam int NPW  = sgi_pkg::NPW;
	localparam int NUMW = sgi_pkg::NUMW;
	localparam int HW   = sgi_pkg::HW;
	localparam int PRW  = sgi_pkg::PRW;
	localparam int PTW  = sgi_pkg::PTW;
	localparam int CTW  = sgi_pkg::CTW;
	localparam int DMW  = sgi_pkg::DMW;
	localparam int NMW  = sgi_pkg::NMW;

	logic en;
	sgi_pkg::div_in_t  div_in;
	sgi_pkg::div_out_t div_out;

	logic [PTW-1:0] pt_q;
	logic [CTW-1:0] ct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q <= PTW'(1);
			ct_q <= CTW'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				sgi_pkg::REG_PRODUCT_THR:   pt_q <= cfg_wdata;
				sgi_pkg::REG_COLLINEAR_THR: ct_q <= cfg_wdata[CTW-1:0];
				default: ;
			endcase
		end
	end

	assign en           = !div_out.vld || seg_out.ready;
	assign seg_in.ready = en;

	// valid chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= seg_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// stage 1: coefficients, corner products
	logic signed [AW-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [PW-1:0] p21_s1, p12_s1, p43_s1, p34_s1;
	logic signed [CW-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1, dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1  <= AW'(seg_in.by_coord) - AW'(seg_in.ay);
			b1_s1  <= AW'(seg_in.ax) - AW'(seg_in.bx);
			a2_s1  <= AW'(seg_in.dy) - AW'(seg_in.cy);
			b2_s1  <= AW'(seg_in.cx) - AW'(seg_in.dx);
			p21_s1 <= seg_in.bx * seg_in.ay;
			p12_s1 <= seg_in.ax * seg_in.by_coord;
			p43_s1 <= seg_in.dx * seg_in.cy;
			p34_s1 <= seg_in.cx * seg_in.dy;
			ax_s1  <= seg_in.ax;
			ay_s1  <= seg_in.ay;
			bx_s1  <= seg_in.bx;
			by_s1  <= seg_in.by_coord;
			cx_s1  <= seg_in.cx;
			cy_s1  <= seg_in.cy;
			dx_s1  <= seg_in.dx;
			dy_s1  <= seg_in.dy;
		end
	end

	// stage 2: constants, side-value terms, denominator terms
	logic signed [AW-1:0]  a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [CCW-1:0] c1_s2, c2_s2;
	logic signed [RPW-1:0] t3a_s2, t3b_s2, t4a_s2, t4b_s2;
	logic signed [RPW-1:0] t1a_s2, t1b_s2, t2a_s2, t2b_s2;
	logic signed [DPW-1:0] d1_s2, d2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s2  <= a1_s1;
			b1_s2  <= b1_s1;
			a2_s2  <= a2_s1;
			b2_s2  <= b2_s1;
			c1_s2  <= CCW'(p21_s1) - CCW'(p12_s1);
			c2_s2  <= CCW'(p43_s1) - CCW'(p34_s1);
			t3a_s2 <= a1_s1 * cx_s1;
			t3b_s2 <= b1_s1 * cy_s1;
			t4a_s2 <= a1_s1 * dx_s1;
			t4b_s2 <= b1_s1 * dy_s1;
			t1a_s2 <= a2_s1 * ax_s1;
			t1b_s2 <= b2_s1 * ay_s1;
			t2a_s2 <= a2_s1 * bx_s1;
			t2b_s2 <= b2_s1 * by_s1;
			d1_s2  <= a1_s1 * b2_s1;
			d2_s2  <= a2_s1 * b1_s1;
		end
	end

	// stage 3: side values, denominator, numerator terms
	logic signed [RW-1:0]   r1_s3, r2_s3, r3_s3, r4_s3;
	logic signed [DENW-1:0] den_s3;
	logic signed [NPW-1:0]  n1_s3, n2_s3, n3_s3, n4_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			r3_s3  <= RW'(t3a_s2) + RW'(t3b_s2) + RW'(c1_s2);
			r4_s3  <= RW'(t4a_s2) + RW'(t4b_s2) + RW'(c1_s2);
			r1_s3  <= RW'(t1a_s2) + RW'(t1b_s2) + RW'(c2_s2);
			r2_s3  <= RW'(t2a_s2) + RW'(t2b_s2) + RW'(c2_s2);
			den_s3 <= DENW'(d1_s2) - DENW'(d2_s2);
			n1_s3  <= b1_s2 * c2_s2;
			n2_s3  <= b2_s2 * c1_s2;
			n3_s3  <= a2_s2 * c1_s2;
			n4_s3  <= a1_s2 * c2_s2;
		end
	end

	// stage 4: same-side test, magnitudes, numerators, collinear test
	logic                   side_c;
	logic [RW-1:0]          m1_c, m2_c, m3_c, m4_c;
	logic [DMW-1:0]         dm_c;
	logic                   side_s4, coll_s4, dneg_s4;
	logic [RW-1:0]          m1_s4, m2_s4, m3_s4, m4_s4;
	logic [DMW-1:0]         dm_s4;
	logic signed [NUMW-1:0] nx_s4, ny_s4;

	always_comb begin
		side_c = ((r3_s3 != '0) && (r4_s3 != '0) && (r3_s3[RW-1] == r4_s3[RW-1])) ||
		         ((r1_s3 != '0) && (r2_s3 != '0) && (r1_s3[RW-1] == r2_s3[RW-1]));
		m1_c = r1_s3[RW-1] ? RW'(-r1_s3) : RW'(r1_s3);
		m2_c = r2_s3[RW-1] ? RW'(-r2_s3) : RW'(r2_s3);
		m3_c = r3_s3[RW-1] ? RW'(-r3_s3) : RW'(r3_s3);
		m4_c = r4_s3[RW-1] ? RW'(-r4_s3) : RW'(r4_s3);
		dm_c = den_s3[DENW-1] ? DMW'(-den_s3) : DMW'(den_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_c;
			m1_s4   <= m1_c;
			m2_s4   <= m2_c;
			m3_s4   <= m3_c;
			m4_s4   <= m4_c;
			dm_s4   <= dm_c;
			dneg_s4 <= den_s3[DENW-1];
			coll_s4 <= (den_s3 == '0) || (dm_c < DMW'(ct_q));
			nx_s4   <= NUMW'(n1_s3) - NUMW'(n2_s3);
			ny_s4   <= NUMW'(n3_s3) - NUMW'(n4_s3);
		end
	end

	// stage 5: side-product partials, numerator magnitudes, quotient signs
	logic [2*HW-1:0] a_ll_s5, a_lh_s5, a_hl_s5, a_hh_s5;
	logic [2*HW-1:0] b_ll_s5, b_lh_s5, b_hl_s5, b_hh_s5;
	logic            side_s5, coll_s5, negx_s5, negy_s5;
	logic [DMW-1:0]  dm_s5;
	logic [NMW-1:0]  nxm_s5, nym_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			a_ll_s5 <= HW'(m1_s4) * HW'(m2_s4);
			a_lh_s5 <= HW'(m1_s4) * HW'(m2_s4 >> HW);
			a_hl_s5 <= HW'(m1_s4 >> HW) * HW'(m2_s4);
			a_hh_s5 <= HW'(m1_s4 >> HW) * HW'(m2_s4 >> HW);
			b_ll_s5 <= HW'(m3_s4) * HW'(m4_s4);
			b_lh_s5 <= HW'(m3_s4) * HW'(m4_s4 >> HW);
			b_hl_s5 <= HW'(m3_s4 >> HW) * HW'(m4_s4);
			b_hh_s5 <= HW'(m3_s4 >> HW) * HW'(m4_s4 >> HW);
			side_s5 <= side_s4;
			coll_s5 <= coll_s4;
			dm_s5   <= dm_s4;
			negx_s5 <= nx_s4[NUMW-1] ^ dneg_s4;
			negy_s5 <= ny_s4[NUMW-1] ^ dneg_s4;
			nxm_s5  <= nx_s4[NUMW-1] ? NMW'(-nx_s4) : NMW'(nx_s4);
			nym_s5  <= ny_s4[NUMW-1] ? NMW'(-ny_s4) : NMW'(ny_s4);
		end
	end

	// stage 6: side products
	logic [PRW-1:0] pa_s6, pb_s6;
	logic           side_s6, coll_s6, negx_s6, negy_s6;
	logic [DMW-1:0] dm_s6;
	logic [NMW-1:0] nxm_s6, nym_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s6   <= (PRW'(a_hh_s5) << (2 * HW)) +
			           ((PRW'(a_lh_s5) + PRW'(a_hl_s5)) << HW) + PRW'(a_ll_s5);
			pb_s6   <= (PRW'(b_hh_s5) << (2 * HW)) +
			           ((PRW'(b_lh_s5) + PRW'(b_hl_s5)) << HW) + PRW'(b_ll_s5);
			side_s6 <= side_s5;
			coll_s6 <= coll_s5;
			negx_s6 <= negx_s5;
			negy_s6 <= negy_s5;
			dm_s6   <= dm_s5;
			nxm_s6  <= nxm_s5;
			nym_s6  <= nym_s5;
		end
	end

	// stage 7: threshold test, final hit decision
	logic           small_c;
	logic           hit_s7, negx_s7, negy_s7;
	logic [DMW-1:0] dm_s7;
	logic [NMW-1:0] nxm_s7, nym_s7;

	assign small_c = (pt_q != '0) && (pa_s6 < PRW'(pt_q)) && (pb_s6 < PRW'(pt_q));

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s7  <= !side_s6 && !small_c && !coll_s6;
			negx_s7 <= negx_s6;
			negy_s7 <= negy_s6;
			dm_s7   <= dm_s6;
			nxm_s7  <= nxm_s6;
			nym_s7  <= nym_s6;
		end
	end

	assign div_in.vld  = vld_s7;
	assign div_in.hit  = hit_s7;
	assign div_in.negx = negx_s7;
	assign div_in.negy = negy_s7;
	assign div_in.nx   = nxm_s7;
	assign div_in.ny   = nym_s7;
	assign div_in.dm   = dm_s7;

	sgi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (div_in),
		.dout   (div_out)
	);

	assign seg_out.valid = div_out.vld;
	assign seg_out.hit   = div_out.hit;
	assign seg_out.ix    = div_out.ix;
	assign seg_out.iy    = div_out.iy;

endmodule

// ----- tb/sv/tb_segment_intersection_2d.sv -----
// Testbench for segment_intersection_2d: directed and random pairs against a local predictor.
module tb_segment_intersection_2d;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		logic signed [sgi_pkg::CW-1:0] ax, ay, bx, by_coord, cx, cy, dx, dy;
	} seg_pair_t;

	typedef struct {
		logic                          hit;
		logic signed [sgi_pkg::CW-1:0] ix;
		logic signed [sgi_pkg::CW-1:0] iy;
	} crossing_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [sgi_pkg::IDXW-1:0]  cfg_idx = '0;
	logic [sgi_pkg::PTW-1:0]   cfg_wdata = '0;

	sgi_in_if  seg_in();
	sgi_out_if seg_out();

	segment_intersection_2d uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .seg_in(seg_in), .seg_out(seg_out)
	);

	always #2 clk = ~clk;

	logic [sgi_pkg::PTW-1:0] prod_thr = sgi_pkg::PTW'(1);
	logic [sgi_pkg::CTW-1:0] coll_thr = sgi_pkg::CTW'(1);
	crossing_t      pending_crossings[$];
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             mismatches = 0;
	int             results_seen = 0;
	int             hits_seen = 0;
	int             items_sent = 0;
	int             quiet_cycles = 0;

	function automatic crossing_t predict_crossing(seg_pair_t s);
		logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
		logic signed [127:0] a1, b1, c1, a2, b2, c2, r1, r2, r3, r4, den, p12, p34, nx, ny;
		crossing_t res;
		res.hit = 1'b0; res.ix = '0; res.iy = '0;
		x1 = 128'(s.ax); y1 = 128'(s.ay); x2 = 128'(s.bx); y2 = 128'(s.by_coord);
		x3 = 128'(s.cx); y3 = 128'(s.cy); x4 = 128'(s.dx); y4 = 128'(s.dy);
		a1 = y2 - y1; b1 = x1 - x2; c1 = x2 * y1 - x1 * y2;
		r3 = a1 * x3 + b1 * y3 + c1;
		r4 = a1 * x4 + b1 * y4 + c1;
		if (r3 != 0 && r4 != 0 && ((r3 < 0) == (r4 < 0))) return res;
		a2 = y4 - y3; b2 = x3 - x4; c2 = x4 * y3 - x3 * y4;
		r1 = a2 * x1 + b2 * y1 + c2;
		r2 = a2 * x2 + b2 * y2 + c2;
		if (r1 != 0 && r2 != 0 && ((r1 < 0) == (r2 < 0))) return res;
		p12 = r1 * r2; if (p12 < 0) p12 = -p12;
		p34 = r3 * r4; if (p34 < 0) p34 = -p34;
		if (p12 < $signed({80'b0, prod_thr}) && p34 < $signed({80'b0, prod_thr})) return res;
		den = a1 * b2 - a2 * b1;
		if (den == 0) return res;
		if ((den < 0 ? -den : den) < $signed({96'b0, coll_thr})) return res;
		nx = (b1 * c2 - b2 * c1) / den;
		ny = (a2 * c1 - a1 * c2) / den;
		res.hit = 1'b1; res.ix = nx[sgi_pkg::CW-1:0]; res.iy = ny[sgi_pkg::CW-1:0];
		return res;
	endfunction

	initial begin
		seg_in.valid = 1'b0;
		{seg_in.ax, seg_in.ay, seg_in.bx, seg_in.by_coord} = '0;
		{seg_in.cx, seg_in.cy, seg_in.dx, seg_in.dy} = '0;
		seg_out.ready = 1'b0;
	end

	always @(posedge clk)
		seg_out.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		crossing_t exp_c;
		if (arst_n && seg_out.valid && seg_out.ready) begin
			results_seen++;
			if (seg_out.hit) hits_seen++;
			if (pending_crossings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result hit=%0b ix=%0d iy=%0d",
					seg_out.hit, seg_out.ix, seg_out.iy);
			end else begin
				exp_c = pending_crossings.pop_front();
				if (seg_out.hit !== exp_c.hit || seg_out.ix !== exp_c.ix ||
						seg_out.iy !== exp_c.iy) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp hit=%0b ix=%0d iy=%0d, got hit=%0b ix=%0d iy=%0d",
							exp_c.hit, exp_c.ix, exp_c.iy, seg_out.hit, seg_out.ix, seg_out.iy);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((seg_in.valid && seg_in.ready) || (seg_out.valid && seg_out.ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_pair(seg_pair_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			seg_in.valid <= 1'b0;
			@(posedge clk);
		end
		seg_in.valid <= 1'b1;
		seg_in.ax <= s.ax; seg_in.ay <= s.ay; seg_in.bx <= s.bx; seg_in.by_coord <= s.by_coord;
		seg_in.cx <= s.cx; seg_in.cy <= s.cy; seg_in.dx <= s.dx; seg_in.dy <= s.dy;
		do @(posedge clk); while (!seg_in.ready);
		pending_crossings = {pending_crossings, predict_crossing(s)};
		items_sent++;
	endtask

	task automatic wait_idle();
		seg_in.valid <= 1'b0;
		@(posedge clk);
		wait (pending_crossings.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_thresholds(logic [sgi_pkg::PTW-1:0] pt, logic [sgi_pkg::CTW-1:0] ct);
		wait_idle();
		cfg_we <= 1'b1; cfg_idx <= sgi_pkg::REG_PRODUCT_THR; cfg_wdata <= pt;
		@(posedge clk);
		cfg_idx <= sgi_pkg::REG_COLLINEAR_THR; cfg_wdata <= {16'b0, ct};
		@(posedge clk);
		cfg_we <= 1'b0;
		prod_thr = pt; coll_thr = ct;
	endtask

	function automatic seg_pair_t mk(int ax, int ay, int bx, int by, int cx, int cy,
			int dx, int dy);
		seg_pair_t s;
		s.ax = sgi_pkg::CW'(ax); s.ay = sgi_pkg::CW'(ay);
		s.bx = sgi_pkg::CW'(bx); s.by_coord = sgi_pkg::CW'(by);
		s.cx = sgi_pkg::CW'(cx); s.cy = sgi_pkg::CW'(cy);
		s.dx = sgi_pkg::CW'(dx); s.dy = sgi_pkg::CW'(dy);
		return s;
	endfunction

	function automatic int srand(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// mostly pairs built to cross, plus small boxes, full-range noise and parallel pairs
	function automatic seg_pair_t random_pair();
		int sel, px, py, ux, uy, wx, wy, ox, oy;
		seg_pair_t s;
		sel = $urandom_range(99);
		if (sel < 50) begin
			px = srand(16000); py = srand(16000);
			ux = srand(4000); uy = srand(4000); wx = srand(4000); wy = srand(4000);
			s = mk(px + ux, py + uy, px - ux, py - uy, px + wx, py + wy, px - wx, py - wy);
		end else if (sel < 70) begin
			s = mk(srand(256), srand(256), srand(256), srand(256),
				srand(256), srand(256), srand(256), srand(256));
		end else if (sel < 90) begin
			s = mk($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		end else begin
			ox = srand(8000); oy = srand(8000);
			s = mk(srand(16000), srand(16000), srand(16000), srand(16000), 0, 0, 0, 0);
			s.cx = sgi_pkg::CW'(s.ax + ox); s.cy = sgi_pkg::CW'(s.ay + oy);
			s.dx = sgi_pkg::CW'(s.bx + ox); s.dy = sgi_pkg::CW'(s.by_coord + oy);
		end
		return s;
	endfunction

	task automatic test_directed();
		send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		send_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_pair(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
		send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(mk(-160, 0, 160, 0, 0, -160, 0, 160));
		send_pair(mk(-163, -17, 171, 29, 5, -201, -13, 187));
		send_pair(mk(0, 0, 160, 160, 160, 160, 320, 0));
		send_pair(mk(0, 0, 160, 0, 80, 0, 80, 160));
		send_pair(mk(0, 0, 160, 0, 0, 16, 160, 16));
		send_pair(mk(0, 0, 160, 0, 320, 0, 480, 0));
		send_pair(mk(0, 0, 160, 0, 80, 16, 80, 48));
		send_pair(mk(0, 0, 1, 1, 0, 1, 1, 0));
		send_pair(mk(0, 0, 2, 1, 0, 1, 2, 0));
		send_pair(mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
		send_pair(mk(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
		send_pair(mk(-32768, -32768, 32767, -32767, -32768, -32767, 32767, -32768));
		write_thresholds(sgi_pkg::PTW'(0), sgi_pkg::CTW'(0));
		send_pair(mk(0, 0, 1, 1, 0, 1, 1, 0));
		send_pair(mk(0, 0, 160, 0, 0, 16, 160, 16));
		send_pair(mk(0, 0, 160, 160, 160, 160, 320, 0));
		send_pair(mk(0, 0, 2, 1, 0, 1, 2, 0));
		write_thresholds(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		send_pair(mk(-160, 0, 160, 0, 0, -160, 0, 160));
	endtask

	task automatic test_threshold_sweep();
		logic [sgi_pkg::PTW-1:0] pts[4] =
			'{48'd0, 48'h1_0000_0000, 48'hFFFF_FFFF_FFFF, 48'd1 << 40};
		logic [sgi_pkg::CTW-1:0] cts[4] = '{32'd0, 32'h0001_0000, 32'hFFFF_FFFF, 32'd256};
		for (int k = 0; k < 4; k++) begin
			write_thresholds(pts[k], cts[k]);
			for (int n = 0; n < 100; n++) send_pair(random_pair());
		end
	endtask

	task automatic test_flow_control();
		int idle_set[4]  = '{0, 50, 0, 34};
		int stall_set[4] = '{0, 0, 50, 34};
		write_thresholds(sgi_pkg::PTW'(1), sgi_pkg::CTW'(1));
		for (int k = 0; k < 4; k++) begin
			send_idle_pct = idle_set[k];
			recv_stall_pct = stall_set[k];
			for (int n = 0; n < 200; n++) send_pair(random_pair());
			write_thresholds(sgi_pkg::PTW'($urandom_range(65535)),
				sgi_pkg::CTW'($urandom_range(255)));
			for (int n = 0; n < 60; n++) send_pair(random_pair());
			write_thresholds(sgi_pkg::PTW'(1), sgi_pkg::CTW'(1));
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_threshold_sweep();
		test_flow_control();
		wait_idle();
		$display("%0d segment pairs sent, %0d results checked, %0d of them hits", items_sent,
			results_seen, hits_seen);
		$display("threshold settings from zero to full scale, four sender/receiver idle mixes");
		if (mismatches == 0)
			$display("Regression PASS");
		else begin
			$display("%0d mismatches", mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- segment_intersection_2d.f -----
sv/sgi_pkg.sv
sv/sgi_in_if.sv
sv/sgi_out_if.sv
sv/sgi_div.sv
sv/segment_intersection_2d.sv
tb/sv/tb_segment_intersection_2d.sv
